/* rtl/teq_pkg.sv */
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants for the timer expiry queue
// Store sizing, command and result codes, configuration bundle.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned REPORT_LIMIT = (CAPACITY < 16) ? CAPACITY : 16;
  localparam int unsigned EXAM_W       = $clog2(REPORT_LIMIT + 1);

  localparam logic [1:0] CFG_MARKER = 2'd0;
  localparam logic [1:0] CFG_PERIOD = 2'd1;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ADD_OK    = 2'd0,
    KIND_ADD_FULL  = 2'd1,
    KIND_EXPIRED   = 2'd2,
    KIND_TICK_DONE = 2'd3
  } kind_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] deadline;
    logic [31:0] value;
    logic [15:0] task_id;
  } cmd_t;

  typedef struct packed {
    logic [31:0] marker;
    logic [15:0] period;
  } cfg_t;

endpackage

/* rtl/teq_front.sv */
// ----------------------------------------------------------------------------
// teq_front: command intake
// Accepts items, classifies them by mode and queues them for the back end.
// ----------------------------------------------------------------------------
module teq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic          mode_i,
  input  logic [63:0]   new_deadline_i,
  input  logic [31:0]   new_value_i,
  input  logic [15:0]   new_task_i,
  output logic          cmd_valid_o,
  output teq_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import teq_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  logic       pop;

  assign busy_o      = (fill_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{op: mode_i ? OP_TICK : OP_ADD, deadline: new_deadline_i,
                             value: new_value_i, task_id: new_task_i};
    end
  end

endmodule

/* rtl/teq_back.sv */
// ----------------------------------------------------------------------------
// teq_back: sorted timer store and tick sequencer
// Shift-register priority queue; ticks drain one due head per cycle or re-arm.
// ----------------------------------------------------------------------------
module teq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  teq_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  teq_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          result_valid_o,
  output logic [1:0]    kind_o,
  output logic [63:0]   exp_deadline_o,
  output logic [31:0]   exp_value_o,
  output logic [15:0]   exp_task_o,
  output logic          task_switch_o,
  output logic          last_o
);
  import teq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_REARM
  } state_e;

  state_e              state_q;
  logic [63:0]         dl_q   [CAPACITY];
  logic [31:0]         val_q  [CAPACITY];
  logic [15:0]         tid_q  [CAPACITY];
  logic [CAPACITY-1:0] valid_q;
  logic [63:0]         count_q;
  logic [EXAM_W-1:0]   exam_q;
  logic                sw_q;
  logic [63:0]         re_dl_q;
  logic [31:0]         re_val_q;
  logic [15:0]         re_tid_q;

  logic                res_valid_q;
  kind_e               kind_q;
  logic [63:0]         res_dl_q;
  logic [31:0]         res_val_q;
  logic [15:0]         res_tid_q;
  logic                res_sw_q;
  logic                res_last_q;

  logic [CAPACITY-1:0] le;
  logic                do_insert;
  logic                do_remove;
  logic [63:0]         ins_dl;
  logic [31:0]         ins_val;
  logic [15:0]         ins_tid;
  logic                due;
  logic [15:0]         per;
  logic [64:0]         re_sum;

  assign due = valid_q[0] && (exam_q < EXAM_W'(REPORT_LIMIT)) && (dl_q[0] <= count_q);
  assign per = (cfg_i.period == 16'd0) ? 16'd1 : cfg_i.period;
  assign re_sum = {1'b0, count_q} + {49'd0, per};
  assign cmd_pop_o = (state_q == ST_IDLE);

  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    ins_dl    = re_dl_q;
    ins_val   = re_val_q;
    ins_tid   = re_tid_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.op == OP_ADD && !valid_q[CAPACITY-1]) begin
          do_insert = 1'b1;
          ins_dl    = cmd_i.deadline;
          ins_val   = cmd_i.value;
          ins_tid   = cmd_i.task_id;
        end
      end
      ST_TICK:  do_remove = due;
      ST_REARM: do_insert = 1'b1;
      default: ;
    endcase
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = valid_q[i] && (dl_q[i] <= ins_dl);
    end
  end

  // Store cells: each takes from itself, its neighbour or the new entry
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      if (!le[0]) begin
        dl_q[0]  <= ins_dl;
        val_q[0] <= ins_val;
        tid_q[0] <= ins_tid;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            dl_q[i]  <= ins_dl;
            val_q[i] <= ins_val;
            tid_q[i] <= ins_tid;
          end else begin
            dl_q[i]  <= dl_q[i-1];
            val_q[i] <= val_q[i-1];
            tid_q[i] <= tid_q[i-1];
          end
        end
      end
    end else if (do_remove) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        dl_q[i]  <= dl_q[i+1];
        val_q[i] <= val_q[i+1];
        tid_q[i] <= tid_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      count_q     <= 64'd0;
      exam_q      <= '0;
      sw_q        <= 1'b0;
      res_valid_q <= 1'b0;
      kind_q      <= KIND_ADD_OK;
      res_last_q  <= 1'b0;
      res_sw_q    <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (do_insert) begin
        valid_q <= {valid_q[CAPACITY-2:0], 1'b1} | valid_q;
      end else if (do_remove) begin
        valid_q <= {1'b0, valid_q[CAPACITY-1:1]};
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.op == OP_ADD) begin
              res_valid_q <= 1'b1;
              kind_q      <= valid_q[CAPACITY-1] ? KIND_ADD_FULL : KIND_ADD_OK;
              res_sw_q    <= 1'b0;
              res_last_q  <= 1'b1;
            end else begin
              count_q <= count_q + 64'd1;
              exam_q  <= '0;
              sw_q    <= 1'b0;
              state_q <= ST_TICK;
            end
          end
        end
        ST_TICK: begin
          if (due) begin
            exam_q <= exam_q + 1'b1;
            if (val_q[0] == cfg_i.marker) begin
              sw_q    <= 1'b1;
              state_q <= ST_REARM;
            end else begin
              res_valid_q <= 1'b1;
              kind_q      <= KIND_EXPIRED;
              res_sw_q    <= 1'b0;
              res_last_q  <= 1'b0;
            end
          end else begin
            res_valid_q <= 1'b1;
            kind_q      <= KIND_TICK_DONE;
            res_sw_q    <= sw_q;
            res_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_REARM: state_q <= ST_TICK;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload side of results and the pending re-arm
  always_ff @(posedge clk_i) begin
    if (state_q == ST_TICK && due) begin
      re_dl_q  <= re_sum[64] ? '1 : re_sum[63:0];
      re_val_q <= val_q[0];
      re_tid_q <= tid_q[0];
      res_dl_q  <= dl_q[0];
      res_val_q <= val_q[0];
      res_tid_q <= tid_q[0];
    end else begin
      res_dl_q  <= 64'd0;
      res_val_q <= 32'd0;
      res_tid_q <= 16'd0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign exp_deadline_o = (kind_q == KIND_EXPIRED) ? res_dl_q : 64'd0;
  assign exp_value_o    = (kind_q == KIND_EXPIRED) ? res_val_q : 32'd0;
  assign exp_task_o     = (kind_q == KIND_EXPIRED) ? res_tid_q : 16'd0;
  assign task_switch_o  = res_sw_q;
  assign last_o         = res_last_q;

`ifndef NO_ASSERTIONS
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_q >> 1) & ~valid_q) == '0)
    else $error("store valid bits not a prefix");
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> (dl_q[0] <= dl_q[1]))
    else $error("store head out of order");
  a_done_ends_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK && !due) |=> (result_valid_o && last_o && state_q == ST_IDLE))
    else $error("tick did not end with a final result");
  a_rearm_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REARM) |=> ($countones(valid_q) == $countones($past(valid_q)) + 1))
    else $error("re-arm did not refill the store");
`endif

endmodule

/* rtl/timer_expiry_queue.sv */
// ----------------------------------------------------------------------------
// timer_expiry_queue: earliest-deadline-first software timer queue
// Add items: the result is registered once the back end pops the item.
// Tick items: a result per expiry, then a done result; marker heads are
//   re-armed, and otherwise the shift cells drain one due head per cycle.
// Up to two items queue while the back end works; busy_o marks a full queue.
// The receiver cannot stall. Reset clears the queue, store and tick count.
// ----------------------------------------------------------------------------
module timer_expiry_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [63:0] new_deadline_i,
  input  logic [31:0] new_value_i,
  input  logic [15:0] new_task_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [63:0] exp_deadline_o,
  output logic [31:0] exp_value_o,
  output logic [15:0] exp_task_o,
  output logic        task_switch_o,
  output logic        last_o
);
  import teq_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Config transfers always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.marker <= 32'h8000_0000;
      cfg_q.period <= 16'd20;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MARKER: cfg_q.marker <= cfg_data_i;
        CFG_PERIOD: cfg_q.period <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  teq_front u_front (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .mode_i,
    .new_deadline_i,
    .new_value_i,
    .new_task_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  teq_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .result_valid_o,
    .kind_o,
    .exp_deadline_o,
    .exp_value_o,
    .exp_task_o,
    .task_switch_o,
    .last_o
  );

endmodule
